// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold on the cycle after the antecedent
`define LSI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold on the same cycle as the antecedent
`define LSI_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lsi_pkg.sv =====
package lsi_pkg;

  localparam int LINE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int FUNC_W   = 2;
  localparam int EN_W     = 4;
  localparam int STAT_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_LINE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MODE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LCD  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LYC    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_EN = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LINE_W-1:0] line_value;
    logic [MODE_W-1:0] new_mode;
    logic              lcd_on;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] stat_value;
    logic              irq_request;
    logic [LINE_W-1:0] current_line;
    logic              frame_ready;
  } out_t;

endpackage

// ===== hdl/lcd_stat_interrupt_line_top.sv =====
// lcd status and interrupt line
//
// item channel: item_valid / item_stall / item carry one event (line update,
// mode change or lcd enable change). result channel: result_valid /
// result_stall / result carry one result per event: status value, irq
// request, current line and frame ready flag.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 lyc compare, 1 interrupt enables); write only while the block is idle.
//
// the input register loads at item acceptance and the result register when
// the item fires, which a receiver stall can hold off. throughput: one
// transaction per cycle while the receiver does not stall; the status logic
// between the two registers is a single short compare/or stage.
// when the receiver stalls, the result register holds its transaction and
// the input register can still take one more item, after which item_stall
// rises until the result is taken.
// reset clears all status state to zero (hblank, line 0, lcd off) and both
// configuration registers; no transaction is in flight after reset.
module lcd_stat_interrupt_line_top
  import lsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  in_t                   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output out_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LINE_W-1:0] lyc_compare;
  logic [EN_W-1:0]   int_enables;

  logic s1_valid;
  in_t  s1_item;
  logic fire;
  out_t core_result;

  assign fire       = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      lyc_compare <= '0;
      int_enables <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LYC:    lyc_compare <= cfg_data[LINE_W-1:0];
        CFG_INT_EN: int_enables <= cfg_data[EN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  lsi_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (s1_item),
    .lyc_compare (lyc_compare),
    .int_enables (int_enables),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

`include "assert_macros.svh"

  `LSI_ASSERT_NOW(a_stall_full, item_stall, s1_valid && result_valid && result_stall, "stall without backlog")
  `LSI_ASSERT_NEXT(a_fire_out, fire, result_valid, "processed item lost")

endmodule

// ===== hdl/lsi_core.sv =====
module lsi_core
  import lsi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  in_t               item,
  input  logic [LINE_W-1:0] lyc_compare,
  input  logic [EN_W-1:0]   int_enables,
  output out_t              result
);

  logic [MODE_W-1:0] ppu_mode;
  logic [LINE_W-1:0] line_count;
  logic              lyc_match_flag;
  logic              stat_line;
  logic              lcd_enabled;
  logic              frame_done;

  logic [MODE_W-1:0] ppu_mode_next;
  logic [LINE_W-1:0] line_count_next;
  logic              lyc_match_flag_next;
  logic              stat_line_next;
  logic              lcd_enabled_next;
  logic              frame_done_next;
  logic              do_eval;
  logic              cond;
  logic              irq;

  always_comb begin
    ppu_mode_next       = ppu_mode;
    line_count_next     = line_count;
    lyc_match_flag_next = lyc_match_flag;
    lcd_enabled_next    = lcd_enabled;
    frame_done_next     = frame_done;
    do_eval             = 1'b0;
    case (item.func)
      FUNC_LINE: begin
        line_count_next     = item.line_value;
        lyc_match_flag_next = (item.line_value == lyc_compare);
        do_eval             = 1'b1;
      end
      FUNC_MODE: begin
        if (item.new_mode != ppu_mode) begin
          ppu_mode_next = item.new_mode;
          do_eval       = 1'b1;
        end
      end
      FUNC_LCD: begin
        if (item.lcd_on != lcd_enabled) begin
          // turning on enters oam scan; both evaluations collapse to one
          lcd_enabled_next    = item.lcd_on;
          line_count_next     = '0;
          frame_done_next     = ~item.lcd_on;
          ppu_mode_next       = item.lcd_on ? MODE_OAM : MODE_HBLANK;
          lyc_match_flag_next = (lyc_compare == '0);
          do_eval             = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cond = (int_enables[0] && ppu_mode_next == MODE_HBLANK) ||
           (int_enables[1] && ppu_mode_next == MODE_VBLANK) ||
           (int_enables[2] && ppu_mode_next == MODE_OAM) ||
           (int_enables[3] && line_count_next == lyc_compare);
    irq            = do_eval && !stat_line && cond && lcd_enabled_next;
    stat_line_next = do_eval ? cond : stat_line;
  end

  assign result.stat_value   = {int_enables, lyc_match_flag_next, ppu_mode_next};
  assign result.irq_request  = irq;
  assign result.current_line = line_count_next;
  assign result.frame_ready  = frame_done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppu_mode       <= MODE_HBLANK;
      line_count     <= '0;
      lyc_match_flag <= 1'b0;
      stat_line      <= 1'b0;
      lcd_enabled    <= 1'b0;
      frame_done     <= 1'b0;
    end else if (fire) begin
      ppu_mode       <= ppu_mode_next;
      line_count     <= line_count_next;
      lyc_match_flag <= lyc_match_flag_next;
      stat_line      <= stat_line_next;
      lcd_enabled    <= lcd_enabled_next;
      frame_done     <= frame_done_next;
    end
  end

`include "assert_macros.svh"

  `LSI_ASSERT_NEXT(a_irq_lcd_on, fire && irq, lcd_enabled && stat_line, "irq without lcd on")
  `LSI_ASSERT_NEXT(a_lcd_off, fire && item.func == FUNC_LCD && !item.lcd_on && lcd_enabled,
    frame_done && line_count == '0 && ppu_mode == MODE_HBLANK, "lcd off state wrong")
  `LSI_ASSERT_NEXT(a_hold, !fire, $stable(line_count) && $stable(ppu_mode) && $stable(stat_line), "state moved without item")

endmodule

// ===== test/lsi_stat_checker.sv =====
module lsi_stat_checker
  import lsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  in_t                   item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  out_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LINE_W-1:0] lyc_r;
  logic [EN_W-1:0]   int_en_r;
  logic [MODE_W-1:0] mode_r;
  logic [LINE_W-1:0] line_r;
  logic              match_r;
  logic              stat_line_r;
  logic              lcd_on_r;
  logic              frame_done_r;

  out_t stat_expected_q[$];

  // recompute the shared status line, report a rising edge while the lcd is on
  function automatic logic update_stat_line();
    logic cond;
    logic req;
    cond = (int_en_r[0] && mode_r == MODE_HBLANK) ||
           (int_en_r[1] && mode_r == MODE_VBLANK) ||
           (int_en_r[2] && mode_r == MODE_OAM) ||
           (int_en_r[3] && line_r == lyc_r);
    req = !stat_line_r && cond && lcd_on_r;
    stat_line_r = cond;
    return req;
  endfunction

  function automatic logic refresh_match();
    match_r = (line_r == lyc_r);
    return update_stat_line();
  endfunction

  function automatic logic enter_mode(input logic [MODE_W-1:0] m);
    if (m == mode_r) return 1'b0;
    mode_r = m;
    return update_stat_line();
  endfunction

  function automatic out_t next_stat_result(input in_t ev);
    out_t r;
    logic irq;
    irq = 1'b0;
    case (ev.func)
      FUNC_LINE: begin
        line_r = ev.line_value;
        irq = refresh_match();
      end
      FUNC_MODE: irq = enter_mode(ev.new_mode);
      FUNC_LCD: begin
        if (ev.lcd_on != lcd_on_r) begin
          lcd_on_r = ev.lcd_on;
          line_r = '0;
          if (!ev.lcd_on) begin
            frame_done_r = 1'b1;
            mode_r = MODE_HBLANK;
            irq = refresh_match();
          end else begin
            frame_done_r = 1'b0;
            irq = enter_mode(MODE_OAM);
            irq = refresh_match() | irq;
          end
        end
      end
      default: ;
    endcase
    r.stat_value = {int_en_r, match_r, mode_r};
    r.irq_request = irq;
    r.current_line = line_r;
    r.frame_ready = frame_done_r;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      lyc_r = '0;
      int_en_r = '0;
      mode_r = MODE_HBLANK;
      line_r = '0;
      match_r = 1'b0;
      stat_line_r = 1'b0;
      lcd_on_r = 1'b0;
      frame_done_r = 1'b0;
      stat_expected_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LYC:    lyc_r = cfg_data;
          CFG_INT_EN: int_en_r = cfg_data[EN_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall)
        stat_expected_q.push_back(next_stat_result(item));
      if (result_valid && !result_stall) begin
        if (stat_expected_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result transaction %p", $realtime, result);
          errors++;
        end else begin
          want = stat_expected_q.pop_front();
          if (want.stat_value !== result.stat_value ||
              want.irq_request !== result.irq_request ||
              want.current_line !== result.current_line ||
              want.frame_ready !== result.frame_ready) begin
            if (errors < 10)
              $display("%0t: mismatch stat %h/%h irq %b/%b line %0d/%0d ready %b/%b (exp/act)",
                       $realtime, want.stat_value, result.stat_value,
                       want.irq_request, result.irq_request,
                       want.current_line, result.current_line,
                       want.frame_ready, result.frame_ready);
            errors++;
          end
        end
      end
      pending = stat_expected_q.size();
    end
  end

endmodule

// ===== test/tb_lcd_stat_interrupt_line_top.sv =====
module tb_lcd_stat_interrupt_line_top;
  import lsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int HOLD_CYCLES     = 150;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 4;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_XFER = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  in_t                   item;
  logic                  result_valid;
  logic                  result_stall;
  out_t                  result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                errors;
  int                pending;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                quiet_cycles;
  bit                hold_request;
  logic [LINE_W-1:0] lyc_now;

  always #2 clk = ~clk;

  lcd_stat_interrupt_line_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  lsi_stat_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  function automatic in_t make_event(input logic [FUNC_W-1:0] f, input logic [LINE_W-1:0] l,
                                     input logic [MODE_W-1:0] m, input logic on);
    in_t ev;
    ev.func = f;
    ev.line_value = l;
    ev.new_mode = m;
    ev.lcd_on = on;
    return ev;
  endfunction

  // mostly line and mode events, lcd kept on most of the time, lines near lyc
  function automatic in_t random_event();
    in_t ev;
    int pick;
    logic [LINE_W-1:0] l;
    ev = in_t'($urandom_range(0, (1 << $bits(in_t)) - 1));
    pick = $urandom_range(99);
    if (pick < 45) begin
      ev.func = FUNC_LINE;
      if ($urandom_range(1) == 0) begin
        l = LINE_W'(int'(lyc_now) + int'($urandom_range(2)) - 1);
        ev.line_value = l;
      end
    end else if (pick < 80) begin
      ev.func = FUNC_MODE;
    end else if (pick < 93) begin
      ev.func = FUNC_LCD;
      ev.lcd_on = ($urandom_range(99) < 75);
    end else begin
      ev.func = FUNC_NONE;
    end
    return ev;
  endfunction

  task automatic send_item(input in_t ev);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item <= ev;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] lyc, input logic [CFG_DATA_W-1:0] en);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LYC;
    cfg_data <= lyc;
    @(posedge clk);
    cfg_index <= CFG_INT_EN;
    cfg_data <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
    lyc_now = lyc;
  endtask

  // receiver: random stall, or one long hold-off when asked
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_t directed[$];
    logic [CFG_DATA_W-1:0] lyc_cfg;
    logic [CFG_DATA_W-1:0] en_cfg;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LYC;
    cfg_data <= '0;
    tx_idle_pct = 19;
    rx_idle_pct = 68;
    hold_request = 1'b0;
    lyc_now = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_config(8'd144, 8'h0F);
    directed.push_back(make_event(FUNC_NONE, 8'hFF, MODE_XFER, 1'b1));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_LINE, 8'd144, MODE_HBLANK, 1'b0));  // match while off
    directed.push_back(make_event(FUNC_LCD, 8'h00, MODE_HBLANK, 1'b1));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_XFER, 1'b0));
    directed.push_back(make_event(FUNC_LINE, 8'd5, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_LINE, 8'd144, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_LINE, 8'd255, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_XFER, 1'b0));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_VBLANK, 1'b0));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_XFER, 1'b0));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_OAM, 1'b0));
    directed.push_back(make_event(FUNC_LCD, 8'h00, MODE_HBLANK, 1'b1));    // already on
    directed.push_back(make_event(FUNC_LCD, 8'hFF, MODE_XFER, 1'b0));
    directed.push_back(make_event(FUNC_LCD, 8'h00, MODE_HBLANK, 1'b0));    // already off
    directed.push_back(make_event(FUNC_LINE, 8'd0, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_LINE, 8'd255, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_XFER, 1'b0));
    directed.push_back(make_event(FUNC_LCD, 8'h00, MODE_HBLANK, 1'b1));
    directed.push_back(make_event(FUNC_MODE, 8'h00, MODE_XFER, 1'b0));
    directed.push_back(make_event(FUNC_LINE, 8'd144, MODE_HBLANK, 1'b0));
    directed.push_back(make_event(FUNC_NONE, 8'h00, MODE_HBLANK, 1'b0));
    foreach (directed[i]) send_item(directed[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          lyc_cfg = CFG_DATA_W'($urandom_range(255));
          en_cfg = CFG_DATA_W'($urandom_range(255));
        end
        1: begin lyc_cfg = 8'd255; en_cfg = 8'hFF; end
        2: begin lyc_cfg = 8'd0; en_cfg = 8'h00; end
        3: begin
          lyc_cfg = CFG_DATA_W'($urandom_range(255));
          en_cfg = CFG_DATA_W'($urandom_range(255));
        end
        4: begin lyc_cfg = CFG_DATA_W'($urandom_range(255)); en_cfg = 8'h0F; end
        default: begin lyc_cfg = 8'd0; en_cfg = 8'h0F; end
      endcase
      set_config(lyc_cfg, en_cfg);
      if (phase < 2) begin
        tx_idle_pct = 19;
        rx_idle_pct = 68;
      end else if (phase < 4) begin
        tx_idle_pct = 68;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming
        if (phase == 0 && n == 100) hold_request = 1'b1;
        send_item(random_event());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
